// ----- src/tks_pkg.sv -----
// shared types, codes and constants for the table key search block
`timescale 1ns / 1ps

package tks_pkg;

  localparam int DATA_W          = 32;
  localparam int ACT_W           = 2;
  localparam int IDX_W           = 6;
  localparam int POS_W           = 6;
  localparam int USED_W          = 7;
  localparam int TABLE_DEPTH_DEF = 64;

  localparam logic [ACT_W-1:0] ACT_LOAD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SEQ  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_BIN  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_CHECK,
    ST_PUSH
  } state_t;

  // result of comparing one table entry against the key
  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_res_t;

endpackage

// ----- src/tks_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps

module tks_ram #(
  parameter int WIDTH = tks_pkg::DATA_W,
  parameter int DEPTH = tks_pkg::TABLE_DEPTH_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/tks_cmp.sv -----
// shared signed compare unit used by both search modes
`timescale 1ns / 1ps

module tks_cmp (
  input  logic [tks_pkg::DATA_W-1:0] entry,
  input  logic [tks_pkg::DATA_W-1:0] key,
  output tks_pkg::cmp_res_t          res
);

  import tks_pkg::*;

  // equality and signed less-than of entry against key
  always_comb begin
    res.eq = (entry == key);
    res.lt = ($signed(entry) < $signed(key));
  end

endmodule

// ----- src/tks_seq.sv -----
// search sequencer: request intake, probe stepping, result register
`timescale 1ns / 1ps

module tks_seq #(
  parameter int TABLE_DEPTH = tks_pkg::TABLE_DEPTH_DEF,
  localparam int AW         = $clog2(TABLE_DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [tks_pkg::ACT_W-1:0]  action,
  input  logic [tks_pkg::IDX_W-1:0]  entry_index,
  input  logic [tks_pkg::DATA_W-1:0] value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       found,
  output logic [tks_pkg::POS_W-1:0]  position,
  input  logic                       cfg_wr_en,
  input  logic [tks_pkg::USED_W-1:0] cfg_wr_data,
  output logic                       ram_wr_en,
  output logic [AW-1:0]              ram_wr_addr,
  output logic                       ram_rd_en,
  output logic [AW-1:0]              ram_rd_addr,
  output logic [tks_pkg::DATA_W-1:0] key,
  input  tks_pkg::cmp_res_t          cmp
);

  import tks_pkg::*;

  localparam int CW = (AW + 1 > USED_W) ? AW + 1 : USED_W;

  state_t state, state_next;

  logic [USED_W-1:0] entries_used;
  logic              mode_bin;
  logic [AW-1:0]     low;
  logic [AW-1:0]     high;
  logic [AW-1:0]     probe;
  logic              hit;

  logic [CW-1:0] used_ext;
  logic [CW-1:0] depth_c;
  logic [CW-1:0] span;
  logic          span_zero;
  logic [AW-1:0] last_idx;
  logic          load_ok;
  logic          accept;
  logic          is_search;
  logic [AW:0]   mid_sum;
  logic [AW-1:0] mid;
  logic          probe_done;
  logic          probe_hit;
  logic          out_free;

  // search span, clipped to the table depth
  assign used_ext  = CW'(entries_used);
  assign depth_c   = CW'(TABLE_DEPTH);
  assign span      = (used_ext > depth_c) ? depth_c : used_ext;
  assign span_zero = (span == '0);
  assign last_idx  = AW'(span - CW'(1));
  assign load_ok   = (CW'(entry_index) < depth_c);

  assign accept    = in_valid && !in_stall;
  assign is_search = action inside {ACT_SEQ, ACT_BIN};
  assign out_free  = !out_valid || !out_stall;

  // binary midpoint, rounded down
  assign mid_sum = {1'b0, low} + {1'b0, high};
  assign mid     = mid_sum[AW:1];

  // decision on the entry just read
  always_comb begin
    probe_hit  = 1'b0;
    probe_done = 1'b0;
    if (cmp.eq) begin
      probe_hit  = 1'b1;
      probe_done = 1'b1;
    end else if (!mode_bin) begin
      probe_done = (probe == last_idx);
    end else if (cmp.lt) begin
      probe_done = (probe == high);
    end else begin
      probe_done = (probe == low);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && is_search) begin
          state_next = span_zero ? ST_PUSH : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = probe_done ? ST_PUSH : ST_ISSUE;
      end
      ST_PUSH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state outputs: intake stall and table port control
  always_comb begin
    in_stall    = 1'b1;
    ram_wr_en   = 1'b0;
    ram_wr_addr = AW'(entry_index);
    ram_rd_en   = 1'b0;
    ram_rd_addr = probe;
    case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        ram_wr_en = in_valid && (action == ACT_LOAD) && load_ok;
      end
      ST_ISSUE: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = mode_bin ? mid : probe;
      end
      ST_CHECK: begin
        in_stall = 1'b1;
      end
      ST_PUSH: begin
        in_stall = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      entries_used <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        entries_used <= cfg_wr_data;
      end
      if (state == ST_PUSH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // search datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept && is_search) begin
      key      <= value;
      mode_bin <= (action == ACT_BIN);
      low      <= '0;
      high     <= last_idx;
      probe    <= '0;
      hit      <= 1'b0;
    end
    if (state == ST_ISSUE) begin
      probe <= ram_rd_addr;
    end
    if (state == ST_CHECK) begin
      hit <= probe_hit;
      if (!probe_done) begin
        if (!mode_bin) begin
          probe <= probe + AW'(1);
        end else if (cmp.lt) begin
          low <= probe + AW'(1);
        end else begin
          high <= probe - AW'(1);
        end
      end
    end
    if (state == ST_PUSH && out_free) begin
      found    <= hit;
      position <= hit ? POS_W'(probe) : '0;
    end
  end

  // a compare always sees data read in the cycle before
  a_check_after_issue: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |-> ($past(state) == ST_ISSUE))
    else $error("compare without a preceding table read");

  // binary window never empty while probing
  a_bin_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ISSUE && mode_bin) |-> (low <= high))
    else $error("binary search window inverted");

  // scan never runs past the last covered entry
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ISSUE && !mode_bin) |-> (probe <= last_idx))
    else $error("sequential scan beyond span");

  // an empty span goes straight to the result
  a_empty_span: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && accept && is_search && span_zero) |=> (state == ST_PUSH))
    else $error("empty search did not finish at once");

  // a miss reports position zero
  a_miss_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (position == '0))
    else $error("miss with nonzero position");

endmodule

// ----- src/table_key_search_top.sv -----
// table key search top: table of signed 32-bit entries with sequential and binary search
// a load gives no result; the block is ready again the next cycle
// a search probes one entry at a time: a registered table read, then the shared compare
// the result is pushed after the last probe, and no new request is taken until then; probes
// up to span for a scan, floor(log2(span))+1 for binary; a stalled earlier result adds wait
// reset clears the sequencer state, entries_used and result valid; table contents are not cleared
`timescale 1ns / 1ps

module table_key_search_top #(
  parameter int TABLE_DEPTH = tks_pkg::TABLE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [tks_pkg::ACT_W-1:0]  action,
  input  logic [tks_pkg::IDX_W-1:0]  entry_index,
  input  logic signed [tks_pkg::DATA_W-1:0] value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       found,
  output logic [tks_pkg::POS_W-1:0]  position,
  input  logic                       cfg_wr_en,
  input  logic [tks_pkg::USED_W-1:0] cfg_wr_data
);

  import tks_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic              ram_rd_en;
  logic [AW-1:0]     ram_rd_addr;
  logic [DATA_W-1:0] ram_rd_data;
  logic [DATA_W-1:0] key;
  cmp_res_t          cmp;

  // sequencer
  tks_seq #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .entry_index (entry_index),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .position    (position),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .key         (key),
    .cmp         (cmp)
  );

  // entry table
  tks_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (value),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // shared compare unit
  tks_cmp u_cmp (
    .entry (ram_rd_data),
    .key   (key),
    .res   (cmp)
  );

endmodule

// ----- test/table_key_search_top_test.sv -----
// testbench for the table key search block: directed table, then random phases
`timescale 1ns / 1ps

module table_key_search_top_test;
  import tks_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNKNOWN = 2'd3;
  localparam int DRAIN_CYCLES  = 2 * TABLE_DEPTH_DEF + 10;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int PHASES        = 8;
  localparam int MIXED_PER_PHASE = 190;
  localparam int HOLD_AFTER    = 200;
  localparam int HOLD_CYCLES   = 400;
  localparam int N_DIRECTED    = 21;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } answer_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [ACT_W-1:0]   act;
    logic [IDX_W-1:0]   idx;
    logic [DATA_W-1:0]  data;
    logic               typed;
    answer_t            answer;
  } row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [ACT_W-1:0]          action = ACT_LOAD;
  logic [IDX_W-1:0]          entry_index = '0;
  logic signed [DATA_W-1:0]  value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      found;
  logic [POS_W-1:0]          position;
  logic                      cfg_wr_en = 1'b0;
  logic [USED_W-1:0]         cfg_wr_data = '0;

  // model state: table copy and search count
  logic signed [DATA_W-1:0]  table_words [TABLE_DEPTH_DEF];
  logic [USED_W-1:0]         entries_used_q = '0;
  answer_t                   pending_answers [$];

  int errors = 0;
  int answers_checked = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int seg_left = 0;
  int seg_mode = 0;

  // directed requests; typed answers only where obvious
  row_t directed_rows [N_DIRECTED] = '{
    '{ROW_REQ, ACT_SEQ,     6'd0,  32'h0000_0000, 1'b1, '{1'b0, 6'd0}},
    '{ROW_REQ, ACT_BIN,     6'd0,  32'h7fff_ffff, 1'b1, '{1'b0, 6'd0}},
    '{ROW_REQ, ACT_UNKNOWN, 6'd63, 32'hffff_ffff, 1'b0, '{1'b0, 6'd0}},
    '{ROW_REQ, ACT_LOAD,    6'd0,  32'h8000_0000, 1'b0, '{1'b0, 6'd0}},
    '{ROW_REQ, ACT_LOAD,    6'd1,  32'hffff_ffff, 1'b0, '{1'b0, 6'd0}},
    '{ROW_REQ, ACT_LOAD,    6'd2,  32'h0000_0000, 1'b0, '{1'b0, 6'd0}},
    '{ROW_REQ, ACT_LOAD,    6'd3,  32'h7fff_ffff, 1'b0, '{1'b0, 6'd0}},
    '{ROW_REQ, ACT_LOAD,    6'd4,  32'hffff_ffff, 1'b0, '{1'b0, 6'd0}},
    '{ROW_CFG, ACT_LOAD,    6'd0,  32'd4,         1'b0, '{1'b0, 6'd0}},
    '{ROW_REQ, ACT_SEQ,     6'd9,  32'h8000_0000, 1'b1, '{1'b1, 6'd0}},
    '{ROW_REQ, ACT_BIN,     6'd0,  32'h7fff_ffff, 1'b1, '{1'b1, 6'd3}},
    '{ROW_REQ, ACT_BIN,     6'd0,  32'hffff_ffff, 1'b1, '{1'b1, 6'd1}},
    '{ROW_REQ, ACT_BIN,     6'd0,  32'h0000_0001, 1'b1, '{1'b0, 6'd0}},
    '{ROW_REQ, ACT_SEQ,     6'd0,  32'h0000_0005, 1'b1, '{1'b0, 6'd0}},
    '{ROW_CFG, ACT_LOAD,    6'd0,  32'd5,         1'b0, '{1'b0, 6'd0}},
    '{ROW_REQ, ACT_SEQ,     6'd0,  32'hffff_ffff, 1'b1, '{1'b1, 6'd1}},
    '{ROW_REQ, ACT_BIN,     6'd0,  32'hffff_ffff, 1'b0, '{1'b0, 6'd0}},
    '{ROW_REQ, ACT_BIN,     6'd0,  32'h7fff_ffff, 1'b0, '{1'b0, 6'd0}},
    '{ROW_CFG, ACT_LOAD,    6'd0,  32'd1,         1'b0, '{1'b0, 6'd0}},
    '{ROW_REQ, ACT_BIN,     6'd0,  32'h8000_0000, 1'b1, '{1'b1, 6'd0}},
    '{ROW_REQ, ACT_SEQ,     6'd0,  32'h0000_0000, 1'b1, '{1'b0, 6'd0}}
  };

  table_key_search_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .entry_index (entry_index),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .position    (position),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // number of entries a search covers, saturated at the table depth
  function automatic int search_span();
    return (entries_used_q > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(entries_used_q);
  endfunction

  // predicted answer of a sequential or binary search for key
  function automatic answer_t search_answer(logic [ACT_W-1:0] act, logic signed [DATA_W-1:0] key);
    answer_t ans;
    int n;
    int lo;
    int hi;
    int mid;
    ans = '{1'b0, '0};
    n = search_span();
    if (act == ACT_SEQ) begin
      for (int i = 0; i < n; i++) begin
        if (table_words[i] == key) begin
          ans = '{1'b1, POS_W'(i)};
          break;
        end
      end
    end else begin
      lo = 0;
      hi = n - 1;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (table_words[mid] == key) begin
          ans = '{1'b1, POS_W'(mid)};
          break;
        end else if (table_words[mid] < key) begin
          lo = mid + 1;
        end else begin
          hi = mid - 1;
        end
      end
    end
    return ans;
  endfunction

  // offer one request in bursts with random gaps; update model on acceptance
  task automatic send_request(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
                              logic [DATA_W-1:0] data, bit predict);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 2);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid    <= 1'b1;
    action      <= act;
    entry_index <= idx;
    value       <= data;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (act == ACT_LOAD) begin
      table_words[idx] = data;
    end else if (predict && (act inside {ACT_SEQ, ACT_BIN})) begin
      pending_answers.push_back(search_answer(act, data));
    end
  endtask

  // write the search count once every request has been answered
  task automatic write_entries_used(logic [USED_W-1:0] count);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    entries_used_q = count;
    burst_left = 0;
  endtask

  // stimulus
  initial begin
    logic [USED_W-1:0] phase_used [PHASES];
    logic [DATA_W-1:0] data;
    logic [ACT_W-1:0]  act;
    longint            cur;
    bit                sorted;
    int                n;
    int                r;
    phase_used = '{7'd64, 7'd127, 7'd63, 7'd2, 7'd1, 7'd0, 7'd100, 7'd33};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part
    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_CFG) begin
        write_entries_used(USED_W'(directed_rows[k].data));
      end else begin
        if (directed_rows[k].typed) pending_answers.push_back(directed_rows[k].answer);
        send_request(directed_rows[k].act, directed_rows[k].idx, directed_rows[k].data,
                     !directed_rows[k].typed);
      end
    end

    // random phases: refill the whole table, then mixed searches, unknown actions and, in unsorted phases, loads
    for (int phase = 0; phase < PHASES; phase++) begin
      sorted = (phase % 2 == 0);
      write_entries_used(phase >= 6 ? USED_W'($urandom_range(0, 127)) : phase_used[phase]);

      // ascending fill keeps the binary search meaningful
      if (sorted) begin
        cur = -64'sd2147483648;
        if ($urandom_range(0, 1)) cur += $urandom_range(0, 1 << 24);
        for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
          if ($urandom_range(0, 7) != 0) cur += $urandom_range(0, 1 << 26);
          if (cur > 64'sd2147483647) cur = 64'sd2147483647;
          if (i == TABLE_DEPTH_DEF - 1 && $urandom_range(0, 1)) cur = 64'sd2147483647;
          send_request(ACT_LOAD, IDX_W'(i), cur[DATA_W-1:0], 1'b1);
        end
      end else begin
        for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
          data = $urandom_range(0, 1) ? ($urandom_range(0, 6) - 3) : $urandom;
          send_request(ACT_LOAD, IDX_W'(i), data, 1'b1);
        end
      end

      n = search_span();
      for (int j = 0; j < MIXED_PER_PHASE; j++) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          send_request(ACT_UNKNOWN, IDX_W'($urandom), $urandom, 1'b1);
        end else if (!sorted && r < 30) begin
          case ($urandom_range(0, 2))
            0:       data = $urandom_range(0, 6) - 3;
            1:       data = table_words[$urandom_range(0, TABLE_DEPTH_DEF - 1)];
            default: data = $urandom;
          endcase
          send_request(ACT_LOAD, IDX_W'($urandom), data, 1'b1);
        end else begin
          act = $urandom_range(0, 1) ? ACT_SEQ : ACT_BIN;
          if (n > 0 && $urandom_range(0, 9) < 7) begin
            data = table_words[$urandom_range(0, n - 1)];
          end else if (n > 0 && $urandom_range(0, 1)) begin
            data = table_words[$urandom_range(0, n - 1)] + 1;
          end else begin
            data = $urandom;
          end
          send_request(act, IDX_W'($urandom), data, 1'b1);
        end
      end
    end

    // drain and report
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("table_key_search_top_test: done, clean");
    end else begin
      $display("table_key_search_top_test: done, errors");
    end
    $finish;
  end

  // receiver stall pattern, with one long hold-off to back up the block
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && answers_checked >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_mode = $urandom_range(0, 2);
        seg_left = $urandom_range(10, 150);
      end
      seg_left--;
      case (seg_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // compare each accepted answer with the oldest prediction
  always @(posedge clk) begin
    answer_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected answer found=%0b position=%0d", $time, found, position);
      end else begin
        want = pending_answers.pop_front();
        answers_checked++;
        if (found !== want.found) begin
          errors++;
          $display("%0t: found expected %0b actual %0b", $time, want.found, found);
        end
        if (position !== want.position) begin
          errors++;
          $display("%0t: position expected %0d actual %0d", $time, want.position, position);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("table_key_search_top_test: done, errors");
      $finish;
    end
  end

endmodule

// ----- filelist.f -----
src/tks_pkg.sv
src/tks_ram.sv
src/tks_cmp.sv
src/tks_seq.sv
src/table_key_search_top.sv
test/table_key_search_top_test.sv
